// File: rtl/spam_pkg.sv
// ----------------------------------------------------------------------------
// spam_pkg
// shared types, constants and helper functions of the pair associative memory
// ----------------------------------------------------------------------------
package spam_pkg;

    localparam int DIM         = 64;
    localparam int MAX_POP     = 32;
    localparam int COUNT_WIDTH = 8;

    localparam int MODE_W   = 3;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int HIT_W    = 7;
    localparam int CFG_W    = 7;
    localparam int SUM_W    = 17;

    localparam int ROWS      = (DIM * (DIM - 1)) / 2;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int ROW_BITS  = DIM * COUNT_WIDTH;
    localparam int KEY_IDX_W = $clog2(MAX_POP);
    localparam int KEY_CNT_W = $clog2(MAX_POP + 1);
    localparam int PTR_W     = $clog2(DIM + 1);
    localparam int DIM_W     = $clog2(DIM);
    localparam int GROUPS    = (DIM + 7) / 8;
    localparam int GRP_W     = 4;
    localparam int PROD_W    = 2 * POS_W + 1;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);

    localparam logic [SUM_W-1:0] SUM_MAX       = {SUM_W{1'b1}};
    localparam logic [CFG_W-1:0] TARGET_RESET  = CFG_W'(10);

    localparam logic [MODE_W-1:0] MODE_KEY    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STORE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RECALL = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FETCH  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_KEY_BAD = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_HIT  = 2'd3;

    typedef enum logic [2:0] {
        OP_KEY,
        OP_STORE,
        OP_DELETE,
        OP_RECALL,
        OP_FETCH,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [POS_W-1:0] pos;
        logic             last;
        logic             range_err;
    } cmd_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PLOAD,
        S_PROW,
        S_PMEM,
        S_POP,
        S_RSTART,
        S_RANK,
        S_HITS,
        S_HCNT1,
        S_HCNT2,
        S_FETCH,
        S_DONE
    } state_t;

    function automatic logic [GRP_W-1:0] count8(input logic [7:0] v);
        logic [GRP_W-1:0] n;
        n = '0;
        for (int b = 0; b < 8; b++)
        begin
            n = n + GRP_W'(v[b]);
        end
        return n;
    endfunction

    function automatic logic [ROW_W-1:0] row_of(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
        logic [PROD_W-1:0] base;
        logic [PROD_W-1:0] tri_n;
        logic [PROD_W-1:0] r;
        base  = PROD_W'(a) * PROD_W'(DIM);
        tri_n = (PROD_W'(a) * (PROD_W'(a) + PROD_W'(1))) >> 1;
        r     = base - tri_n + PROD_W'(b) - PROD_W'(a) - PROD_W'(1);
        return r[ROW_W-1:0];
    endfunction

endpackage

// File: rtl/spam_if.sv
// ----------------------------------------------------------------------------
// spam_if
// word channels of the pair associative memory
// ----------------------------------------------------------------------------
interface spam_in_if;
    logic                          valid;
    logic                          ready;
    logic [spam_pkg::MODE_W-1:0]   mode;
    logic [spam_pkg::POS_W-1:0]    position;
    logic                          last;

    modport source (output valid, output mode, output position, output last, input ready);
    modport sink (input valid, input mode, input position, input last, output ready);
endinterface

interface spam_out_if;
    logic                          valid;
    logic                          ready;
    logic [spam_pkg::STATUS_W-1:0] status;
    logic [spam_pkg::HIT_W-1:0]    hit_count;
    logic [spam_pkg::POS_W-1:0]    position_out;
    logic                          last_hit;

    modport source (output valid, output status, output hit_count, output position_out,
                    output last_hit, input ready);
    modport sink (input valid, input status, input hit_count, input position_out,
                  input last_hit, output ready);
endinterface

// File: rtl/spam_front.sv
// ----------------------------------------------------------------------------
// spam_front
// takes input words, decodes the mode and checks the position range
// ----------------------------------------------------------------------------
module spam_front
(
    spam_in_if.sink         item,
    input  logic            full,
    output logic            push,
    output spam_pkg::cmd_t  cmd
);

    always_comb
    begin
        cmd.pos       = item.position;
        cmd.last      = item.last;
        cmd.range_err = spam_pkg::PTR_W'(item.position) >= spam_pkg::PTR_W'(spam_pkg::DIM);
        case (item.mode)
            spam_pkg::MODE_KEY:    cmd.op = spam_pkg::OP_KEY;
            spam_pkg::MODE_STORE:  cmd.op = spam_pkg::OP_STORE;
            spam_pkg::MODE_DELETE: cmd.op = spam_pkg::OP_DELETE;
            spam_pkg::MODE_RECALL: cmd.op = spam_pkg::OP_RECALL;
            spam_pkg::MODE_FETCH:  cmd.op = spam_pkg::OP_FETCH;
            default:               cmd.op = spam_pkg::OP_NONE;
        endcase
    end

    assign item.ready = !full;
    assign push       = item.valid && !full;

endmodule

// File: rtl/spam_queue.sv
// ----------------------------------------------------------------------------
// spam_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module spam_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  spam_pkg::cmd_t  push_cmd,
    output logic            full,
    output logic            q_valid,
    input  logic            q_ready,
    output spam_pkg::cmd_t  q_cmd
);

    spam_pkg::cmd_t                  entry_reg [spam_pkg::QDEPTH];
    logic [spam_pkg::QPTR_W-1:0]     wr_reg;
    logic [spam_pkg::QPTR_W-1:0]     rd_reg;
    logic [spam_pkg::QPTR_W:0]       cnt_reg;
    logic                            pop;

    assign full    = cnt_reg == (spam_pkg::QPTR_W + 1)'(spam_pkg::QDEPTH);
    assign q_valid = cnt_reg != '0;
    assign q_cmd   = entry_reg[rd_reg];
    assign pop     = q_valid && q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/spam_back.sv
// ----------------------------------------------------------------------------
// spam_back
// executes commands: key capture, counter updates, recall, ranking and fetch
// ----------------------------------------------------------------------------
module spam_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  spam_pkg::cmd_t              q_cmd,
    input  logic                        cfg_we,
    input  logic [spam_pkg::CFG_W-1:0]  cfg_data,
    spam_out_if.source                  result
);

    localparam int DIM   = spam_pkg::DIM;
    localparam int CW    = spam_pkg::COUNT_WIDTH;
    localparam int SUM_W = spam_pkg::SUM_W;

    spam_pkg::state_t state_reg;
    spam_pkg::state_t state_next;

    // key store
    logic [spam_pkg::POS_W-1:0]     key_mem [spam_pkg::MAX_POP];
    logic [spam_pkg::POS_W-1:0]     key_q_reg;
    logic [spam_pkg::KEY_IDX_W-1:0] key_raddr;
    logic [spam_pkg::KEY_CNT_W-1:0] key_cnt_reg;
    logic                           key_closed_reg;
    logic [spam_pkg::POS_W-1:0]     key_last_reg;

    // counter memory
    logic [spam_pkg::ROW_BITS-1:0]  mem [spam_pkg::ROWS];
    logic [spam_pkg::ROW_BITS-1:0]  mem_q_reg;
    logic [spam_pkg::ROW_BITS-1:0]  mem_wdata;
    logic [spam_pkg::ROW_BITS-1:0]  row_mod;
    logic [spam_pkg::ROW_W-1:0]     mem_waddr;
    logic                           mem_we;
    logic [spam_pkg::ROW_W-1:0]     clr_reg;
    logic [spam_pkg::ROW_W-1:0]     row_reg;

    spam_pkg::cmd_t                 cmd_reg;
    logic [spam_pkg::KEY_IDX_W-1:0] i_reg;
    logic [spam_pkg::KEY_IDX_W-1:0] j_reg;
    logic [spam_pkg::POS_W-1:0]     a_reg;

    // recall and ranking
    logic [SUM_W-1:0]               sums_reg [DIM];
    logic [SUM_W-1:0]               sum_next [DIM];
    logic [SUM_W-1:0]               rot_reg [DIM];
    logic [SUM_W-1:0]               cand1_reg;
    logic [SUM_W-1:0]               cand2_reg;
    logic [SUM_W-1:0]               thr_reg;
    logic [SUM_W-1:0]               thr_eff;
    logic [DIM-1:0]                 gtv_reg;
    logic [DIM-1:0]                 gev_reg;
    logic [DIM-1:0]                 gt_vec;
    logic [DIM-1:0]                 ge_vec;
    logic [spam_pkg::GRP_W-1:0]     gtg_reg [spam_pkg::GROUPS];
    logic [spam_pkg::GRP_W-1:0]     geg_reg [spam_pkg::GROUPS];
    logic [spam_pkg::GRP_W-1:0]     hgrp_reg [spam_pkg::GROUPS];
    logic [spam_pkg::GROUPS*8-1:0]  gt_pad;
    logic [spam_pkg::GROUPS*8-1:0]  ge_pad;
    logic [spam_pkg::GROUPS*8-1:0]  hit_pad;
    logic [spam_pkg::PTR_W-1:0]     gt_sum;
    logic [spam_pkg::PTR_W-1:0]     ge_sum;
    logic [spam_pkg::PTR_W-1:0]     hit_sum;
    logic [spam_pkg::PTR_W-1:0]     rank_cnt_reg;
    logic                           p1_reg;
    logic                           p2_reg;
    logic [spam_pkg::PTR_W-1:0]     k_eff;
    logic [DIM-1:0]                 hit_vec_reg;
    logic [spam_pkg::PTR_W-1:0]     hit_total_reg;
    logic [spam_pkg::PTR_W-1:0]     fptr_reg;
    logic [DIM-1:0]                 above_vec;
    logic [spam_pkg::DIM_W-1:0]     fpos;
    logic [spam_pkg::CFG_W-1:0]     target_reg;

    // result staging and output word
    logic [spam_pkg::STATUS_W-1:0]  res_status_reg;
    logic [spam_pkg::POS_W-1:0]     res_pos_reg;
    logic                           res_last_reg;
    logic                           out_valid_reg;
    logic [spam_pkg::STATUS_W-1:0]  out_status_reg;
    logic [spam_pkg::HIT_W-1:0]     out_hit_reg;
    logic [spam_pkg::POS_W-1:0]     out_pos_reg;
    logic                           out_last_reg;

    logic [spam_pkg::KEY_CNT_W-1:0] eff_cnt;
    logic                           key_bad;
    logic                           has_pairs;
    logic                           more_j;
    logic                           more_i;
    logic                           is_apply;
    logic                           rank_issue;
    logic                           out_free;
    logic                           fetch_end;
    logic                           hit_here;

    assign eff_cnt    = key_closed_reg ? '0 : key_cnt_reg;
    assign key_bad    = (eff_cnt >= spam_pkg::KEY_CNT_W'(spam_pkg::MAX_POP))
                        || (eff_cnt != '0 && q_cmd.pos <= key_last_reg);
    assign has_pairs  = key_cnt_reg >= spam_pkg::KEY_CNT_W'(2);
    assign more_j     = (spam_pkg::KEY_CNT_W'(j_reg) + spam_pkg::KEY_CNT_W'(1)) < key_cnt_reg;
    assign more_i     = (spam_pkg::KEY_CNT_W'(i_reg) + spam_pkg::KEY_CNT_W'(2)) < key_cnt_reg;
    assign is_apply   = cmd_reg.op == spam_pkg::OP_STORE || cmd_reg.op == spam_pkg::OP_DELETE;
    assign rank_issue = rank_cnt_reg < spam_pkg::PTR_W'(DIM);
    assign out_free   = !out_valid_reg || result.ready;
    assign fpos       = fptr_reg[spam_pkg::DIM_W-1:0];
    assign fetch_end  = fptr_reg >= spam_pkg::PTR_W'(DIM);
    assign hit_here   = !fetch_end && hit_vec_reg[fpos];
    assign q_ready    = state_reg == spam_pkg::S_IDLE;
    assign thr_eff    = (thr_reg == '0) ? SUM_W'(1) : thr_reg;

    always_comb
    begin
        if (target_reg == '0)
        begin
            k_eff = spam_pkg::PTR_W'(1);
        end
        else if (spam_pkg::PTR_W'(target_reg) > spam_pkg::PTR_W'(DIM))
        begin
            k_eff = spam_pkg::PTR_W'(DIM);
        end
        else
        begin
            k_eff = spam_pkg::PTR_W'(target_reg);
        end
    end

    // lane logic
    always_comb
    begin
        for (int c = 0; c < DIM; c++)
        begin
            logic [CW-1:0]    lane;
            logic [SUM_W:0]   s;
            lane = mem_q_reg[c*CW +: CW];
            s    = (SUM_W + 1)'(sums_reg[c]) + (SUM_W + 1)'(lane);
            sum_next[c] = (s > (SUM_W + 1)'(spam_pkg::SUM_MAX)) ? spam_pkg::SUM_MAX
                                                                : s[SUM_W-1:0];
            if (spam_pkg::POS_W'(c) == cmd_reg.pos)
            begin
                if (cmd_reg.op == spam_pkg::OP_STORE)
                begin
                    row_mod[c*CW +: CW] = lane + CW'(1);
                end
                else
                begin
                    row_mod[c*CW +: CW] = (lane == '0) ? lane : lane - CW'(1);
                end
            end
            else
            begin
                row_mod[c*CW +: CW] = lane;
            end
            gt_vec[c]    = sums_reg[c] > rot_reg[0];
            ge_vec[c]    = sums_reg[c] >= rot_reg[0];
            above_vec[c] = hit_vec_reg[c] && (spam_pkg::DIM_W'(c) > fpos);
        end
    end

    assign gt_pad  = (spam_pkg::GROUPS*8)'(gtv_reg);
    assign ge_pad  = (spam_pkg::GROUPS*8)'(gev_reg);
    assign hit_pad = (spam_pkg::GROUPS*8)'(hit_vec_reg);

    always_comb
    begin
        gt_sum  = '0;
        ge_sum  = '0;
        hit_sum = '0;
        for (int g = 0; g < spam_pkg::GROUPS; g++)
        begin
            gt_sum  = gt_sum + spam_pkg::PTR_W'(gtg_reg[g]);
            ge_sum  = ge_sum + spam_pkg::PTR_W'(geg_reg[g]);
            hit_sum = hit_sum + spam_pkg::PTR_W'(hgrp_reg[g]);
        end
    end

    assign mem_we    = state_reg == spam_pkg::S_CLEAR || (state_reg == spam_pkg::S_POP && is_apply);
    assign mem_waddr = (state_reg == spam_pkg::S_CLEAR) ? clr_reg : row_reg;
    assign mem_wdata = (state_reg == spam_pkg::S_CLEAR) ? '0 : row_mod;

    // next state
    always_comb
    begin
        state_next = state_reg;
        key_raddr  = '0;
        case (state_reg)
            spam_pkg::S_CLEAR:
            begin
                if (clr_reg == spam_pkg::ROW_W'(spam_pkg::ROWS - 1))
                begin
                    state_next = spam_pkg::S_IDLE;
                end
            end
            spam_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_cmd.op)
                        spam_pkg::OP_STORE, spam_pkg::OP_DELETE:
                        begin
                            state_next = (!q_cmd.range_err && has_pairs) ? spam_pkg::S_PLOAD
                                                                         : spam_pkg::S_DONE;
                        end
                        spam_pkg::OP_RECALL:
                        begin
                            state_next = has_pairs ? spam_pkg::S_PLOAD : spam_pkg::S_RSTART;
                        end
                        spam_pkg::OP_FETCH: state_next = spam_pkg::S_FETCH;
                        default:            state_next = spam_pkg::S_DONE;
                    endcase
                end
            end
            spam_pkg::S_PLOAD:
            begin
                key_raddr  = j_reg;
                state_next = spam_pkg::S_PROW;
            end
            spam_pkg::S_PROW: state_next = spam_pkg::S_PMEM;
            spam_pkg::S_PMEM: state_next = spam_pkg::S_POP;
            spam_pkg::S_POP:
            begin
                if (more_j)
                begin
                    key_raddr  = j_reg + 1'b1;
                    state_next = spam_pkg::S_PROW;
                end
                else if (more_i)
                begin
                    key_raddr  = i_reg + 1'b1;
                    state_next = spam_pkg::S_PLOAD;
                end
                else
                begin
                    state_next = is_apply ? spam_pkg::S_DONE : spam_pkg::S_RSTART;
                end
            end
            spam_pkg::S_RSTART: state_next = spam_pkg::S_RANK;
            spam_pkg::S_RANK:
            begin
                if (!rank_issue && !p1_reg && !p2_reg)
                begin
                    state_next = spam_pkg::S_HITS;
                end
            end
            spam_pkg::S_HITS:  state_next = spam_pkg::S_HCNT1;
            spam_pkg::S_HCNT1: state_next = spam_pkg::S_HCNT2;
            spam_pkg::S_HCNT2: state_next = spam_pkg::S_DONE;
            spam_pkg::S_FETCH:
            begin
                if (fetch_end || hit_here || fpos == spam_pkg::DIM_W'(DIM - 1))
                begin
                    state_next = spam_pkg::S_DONE;
                end
            end
            spam_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = spam_pkg::S_IDLE;
                end
            end
            default: state_next = spam_pkg::S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= spam_pkg::S_CLEAR;
            clr_reg        <= '0;
            key_cnt_reg    <= '0;
            key_closed_reg <= 1'b0;
            rank_cnt_reg   <= '0;
            p1_reg         <= 1'b0;
            p2_reg         <= 1'b0;
            hit_vec_reg    <= '0;
            hit_total_reg  <= '0;
            fptr_reg       <= '0;
            target_reg     <= spam_pkg::TARGET_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                target_reg <= cfg_data;
            end
            if (state_reg == spam_pkg::S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                spam_pkg::S_CLEAR: clr_reg <= clr_reg + 1'b1;
                spam_pkg::S_IDLE:
                begin
                    if (q_valid && q_cmd.op == spam_pkg::OP_KEY)
                    begin
                        key_closed_reg <= q_cmd.last;
                        if (q_cmd.range_err || key_bad)
                        begin
                            key_cnt_reg <= eff_cnt;
                        end
                        else
                        begin
                            key_cnt_reg <= eff_cnt + 1'b1;
                        end
                    end
                end
                spam_pkg::S_RSTART:
                begin
                    rank_cnt_reg <= '0;
                    p1_reg       <= 1'b0;
                    p2_reg       <= 1'b0;
                end
                spam_pkg::S_RANK:
                begin
                    if (rank_issue)
                    begin
                        rank_cnt_reg <= rank_cnt_reg + 1'b1;
                    end
                    p1_reg <= rank_issue;
                    p2_reg <= p1_reg;
                end
                spam_pkg::S_HITS:
                begin
                    for (int c = 0; c < DIM; c++)
                    begin
                        hit_vec_reg[c] <= sums_reg[c] >= thr_eff;
                    end
                end
                spam_pkg::S_HCNT2:
                begin
                    hit_total_reg <= hit_sum;
                    fptr_reg      <= '0;
                end
                spam_pkg::S_FETCH:
                begin
                    if (hit_here)
                    begin
                        fptr_reg <= fptr_reg + 1'b1;
                    end
                    else if (fetch_end || fpos == spam_pkg::DIM_W'(DIM - 1))
                    begin
                        fptr_reg <= spam_pkg::PTR_W'(DIM);
                    end
                    else
                    begin
                        fptr_reg <= fptr_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        key_q_reg <= key_mem[key_raddr];
        if (state_reg == spam_pkg::S_DONE && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_hit_reg    <= spam_pkg::HIT_W'(hit_total_reg);
            out_pos_reg    <= res_pos_reg;
            out_last_reg   <= res_last_reg;
        end
        case (state_reg)
            spam_pkg::S_IDLE:
            begin
                cmd_reg        <= q_cmd;
                i_reg          <= '0;
                j_reg          <= spam_pkg::KEY_IDX_W'(1);
                res_status_reg <= spam_pkg::ST_OK;
                res_pos_reg    <= '0;
                res_last_reg   <= 1'b0;
                if (q_valid)
                begin
                    if (q_cmd.op == spam_pkg::OP_RECALL)
                    begin
                        for (int c = 0; c < DIM; c++)
                        begin
                            sums_reg[c] <= '0;
                        end
                    end
                    if (q_cmd.range_err && q_cmd.op != spam_pkg::OP_RECALL
                        && q_cmd.op != spam_pkg::OP_FETCH && q_cmd.op != spam_pkg::OP_NONE)
                    begin
                        res_status_reg <= spam_pkg::ST_RANGE;
                    end
                    else if (q_cmd.op == spam_pkg::OP_KEY)
                    begin
                        if (key_bad)
                        begin
                            res_status_reg <= spam_pkg::ST_KEY_BAD;
                        end
                        else
                        begin
                            key_mem[eff_cnt[spam_pkg::KEY_IDX_W-1:0]] <= q_cmd.pos;
                            key_last_reg <= q_cmd.pos;
                        end
                    end
                end
            end
            spam_pkg::S_PLOAD: a_reg   <= key_q_reg;
            spam_pkg::S_PROW:  row_reg <= spam_pkg::row_of(a_reg, key_q_reg);
            spam_pkg::S_POP:
            begin
                if (!is_apply)
                begin
                    for (int c = 0; c < DIM; c++)
                    begin
                        sums_reg[c] <= sum_next[c];
                    end
                end
                if (more_j)
                begin
                    j_reg <= j_reg + 1'b1;
                end
                else if (more_i)
                begin
                    i_reg <= i_reg + 1'b1;
                    j_reg <= i_reg + spam_pkg::KEY_IDX_W'(2);
                end
            end
            spam_pkg::S_RSTART:
            begin
                thr_reg <= '0;
                for (int c = 0; c < DIM; c++)
                begin
                    rot_reg[c] <= sums_reg[c];
                end
            end
            spam_pkg::S_RANK:
            begin
                if (rank_issue)
                begin
                    cand1_reg <= rot_reg[0];
                    gtv_reg   <= gt_vec;
                    gev_reg   <= ge_vec;
                    for (int c = 0; c < DIM; c++)
                    begin
                        rot_reg[c] <= rot_reg[(c + 1) % DIM];
                    end
                end
                if (p1_reg)
                begin
                    cand2_reg <= cand1_reg;
                    for (int g = 0; g < spam_pkg::GROUPS; g++)
                    begin
                        gtg_reg[g] <= spam_pkg::count8(gt_pad[g*8 +: 8]);
                        geg_reg[g] <= spam_pkg::count8(ge_pad[g*8 +: 8]);
                    end
                end
                if (p2_reg && gt_sum < k_eff && ge_sum >= k_eff)
                begin
                    thr_reg <= cand2_reg;
                end
            end
            spam_pkg::S_HCNT1:
            begin
                for (int g = 0; g < spam_pkg::GROUPS; g++)
                begin
                    hgrp_reg[g] <= spam_pkg::count8(hit_pad[g*8 +: 8]);
                end
            end
            spam_pkg::S_FETCH:
            begin
                if (hit_here)
                begin
                    res_pos_reg  <= spam_pkg::POS_W'(fpos);
                    res_last_reg <= !(|above_vec);
                end
                else if (fetch_end || fpos == spam_pkg::DIM_W'(DIM - 1))
                begin
                    res_status_reg <= spam_pkg::ST_NO_HIT;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == spam_pkg::S_PMEM)
        begin
            mem_q_reg <= mem[row_reg];
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = out_status_reg;
    assign result.hit_count    = out_hit_reg;
    assign result.position_out = out_pos_reg;
    assign result.last_hit     = out_last_reg;

endmodule

// File: rtl/sparse_pair_associative_memory_core.sv
// ----------------------------------------------------------------------------
// sparse_pair_associative_memory_core
// pair-addressed associative memory of 8-bit counters with sparse recall
// ----------------------------------------------------------------------------
// Items are taken one at a time. After reset the counter memory (2016 rows of
// 64 counters) is cleared at one row per cycle. While it is being cleared,
// only the two queue entries can take words and no result is produced. A key,
// unknown-mode or out-of-range store or delete item goes from idle straight to
// the result stage of the back end. Store and delete visit each key pair: the
// row is computed, read, modified and written back, with a key load step first
// when the first key position of the pair changes. A recall reads the row of
// each key pair in the same way and adds it into the 64 sums, then ranks the
// sums and counts the hits. A fetch scans one position per cycle. A two-entry
// command queue lets input words be taken while the back end is busy.
module sparse_pair_associative_memory_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    spam_in_if.sink                     item,
    spam_out_if.source                  result,
    input  logic                        cfg_we,
    input  logic [spam_pkg::CFG_W-1:0]  cfg_data
);

    spam_pkg::cmd_t push_cmd;
    spam_pkg::cmd_t q_cmd;
    logic           push;
    logic           full;
    logic           q_valid;
    logic           q_ready;

    spam_front u_front
    (
        .item (item),
        .full (full),
        .push (push),
        .cmd  (push_cmd)
    );

    spam_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    spam_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .result   (result)
    );

endmodule

// File: rtl/spam_checker.sv
// ----------------------------------------------------------------------------
// spam_checker
// port-level checks of the result word channel
// ----------------------------------------------------------------------------
module spam_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           valid,
    input  logic                           ready,
    input  logic [spam_pkg::STATUS_W-1:0]  status,
    input  logic [spam_pkg::HIT_W-1:0]     hit_count,
    input  logic [spam_pkg::POS_W-1:0]     position_out,
    input  logic                           last_hit
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(status) && $stable(position_out)
                            && $stable(last_hit) && $stable(hit_count))
        else $error("result word changed while stalled");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status != spam_pkg::ST_OK |-> position_out == '0 && !last_hit)
        else $error("error word carries a fetched position");

    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> hit_count <= spam_pkg::HIT_W'(spam_pkg::DIM))
        else $error("hit count beyond dimension");

    a_no_hit_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && hit_count == '0 |-> !last_hit)
        else $error("last hit flagged with no hits");

endmodule

bind sparse_pair_associative_memory_core spam_checker u_spam_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .valid        (result.valid),
    .ready        (result.ready),
    .status       (result.status),
    .hit_count    (result.hit_count),
    .position_out (result.position_out),
    .last_hit     (result.last_hit)
);

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the pair associative memory: key, store, delete,
// recall and fetch words are driven with random gaps and stalls, every result
// word is checked against a predictor kept in a small scoreboard class
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [spam_pkg::MODE_W-1:0] MODE_SPARE_A = 3'd5;
    localparam logic [spam_pkg::MODE_W-1:0] MODE_SPARE_B = 3'd6;
    localparam logic [spam_pkg::MODE_W-1:0] MODE_SPARE_C = 3'd7;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [spam_pkg::STATUS_W-1:0] status;
        logic [spam_pkg::HIT_W-1:0]    hit_count;
        logic [spam_pkg::POS_W-1:0]    position_out;
        logic                          last_hit;
    } answer_t;

    class memory_scoreboard;
        logic [spam_pkg::COUNT_WIDTH-1:0] counters [spam_pkg::ROWS*spam_pkg::DIM];
        logic [spam_pkg::POS_W-1:0]       key_pos [spam_pkg::MAX_POP];
        int                               key_len;
        bit                               key_done;
        logic [spam_pkg::SUM_W-1:0]       sums [spam_pkg::DIM];
        logic [spam_pkg::SUM_W-1:0]       threshold;
        int                               fetch_ptr;
        int                               hits;
        int                               sparsity;
        answer_t                          pending [$];
        int                               err_count;
        int                               checked;

        function new();
            foreach (counters[i]) counters[i] = '0;
            foreach (sums[i]) sums[i] = '0;
            key_len = 0;
            key_done = 0;
            threshold = 1;
            fetch_ptr = 0;
            hits = 0;
            sparsity = spam_pkg::TARGET_RESET;
            err_count = 0;
            checked = 0;
        endfunction

        function int pair_row(int a, int b);
            return a * spam_pkg::DIM - (a * (a + 1)) / 2 + (b - a - 1);
        endfunction

        function void set_sparsity(logic [spam_pkg::CFG_W-1:0] v);
            sparsity = v;
        endfunction

        function void apply_column(int col, bit inc);
            int idx;
            for (int i = 0; i + 1 < key_len; i++)
                for (int j = i + 1; j < key_len; j++)
                begin
                    idx = pair_row(key_pos[i], key_pos[j]) * spam_pkg::DIM + col;
                    if (inc)
                        counters[idx] = counters[idx] + 1'b1;
                    else if (counters[idx] != 0)
                        counters[idx] = counters[idx] - 1'b1;
                end
        endfunction

        function void do_recall();
            int base;
            int k;
            int ge;
            int gt;
            logic [spam_pkg::SUM_W:0] s;
            logic [spam_pkg::SUM_W-1:0] thr;
            thr = '0;
            foreach (sums[c]) sums[c] = '0;
            for (int i = 0; i + 1 < key_len; i++)
                for (int j = i + 1; j < key_len; j++)
                begin
                    base = pair_row(key_pos[i], key_pos[j]) * spam_pkg::DIM;
                    for (int c = 0; c < spam_pkg::DIM; c++)
                    begin
                        s = sums[c] + counters[base + c];
                        sums[c] = (s > spam_pkg::SUM_MAX) ? spam_pkg::SUM_MAX
                                                          : s[spam_pkg::SUM_W-1:0];
                    end
                end
            k = sparsity;
            if (k == 0) k = 1;
            if (k > spam_pkg::DIM) k = spam_pkg::DIM;
            for (int i = 0; i < spam_pkg::DIM; i++)
            begin
                ge = 0;
                gt = 0;
                for (int j = 0; j < spam_pkg::DIM; j++)
                begin
                    if (sums[j] >= sums[i]) ge++;
                    if (sums[j] > sums[i]) gt++;
                end
                if (gt < k && ge >= k) thr = sums[i];
            end
            if (thr == 0) thr = 1;
            threshold = thr;
            hits = 0;
            for (int c = 0; c < spam_pkg::DIM; c++)
                if (sums[c] >= thr) hits++;
            fetch_ptr = 0;
        endfunction

        // predict the answer to one accepted input word
        function void note(logic [spam_pkg::MODE_W-1:0] md, logic [spam_pkg::POS_W-1:0] ps,
                           logic lst);
            answer_t a;
            int p;
            int q;
            a = '0;
            case (md)
                spam_pkg::MODE_KEY:
                begin
                    if (key_done)
                    begin
                        key_len = 0;
                        key_done = 0;
                    end
                    if (key_len >= spam_pkg::MAX_POP
                        || (key_len > 0 && ps <= key_pos[key_len-1]))
                        a.status = spam_pkg::ST_KEY_BAD;
                    else
                    begin
                        key_pos[key_len] = ps;
                        key_len++;
                    end
                    if (lst) key_done = 1;
                end
                spam_pkg::MODE_STORE:  apply_column(ps, 1);
                spam_pkg::MODE_DELETE: apply_column(ps, 0);
                spam_pkg::MODE_RECALL: do_recall();
                spam_pkg::MODE_FETCH:
                begin
                    p = fetch_ptr;
                    while (p < spam_pkg::DIM && sums[p] < threshold) p++;
                    if (p >= spam_pkg::DIM)
                    begin
                        a.status = spam_pkg::ST_NO_HIT;
                        fetch_ptr = spam_pkg::DIM;
                    end
                    else
                    begin
                        a.position_out = spam_pkg::POS_W'(p);
                        q = p + 1;
                        fetch_ptr = q;
                        while (q < spam_pkg::DIM && sums[q] < threshold) q++;
                        a.last_hit = (q >= spam_pkg::DIM);
                    end
                end
                default: ;
            endcase
            a.hit_count = spam_pkg::HIT_W'(hits);
            pending.push_back(a);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch on result %0d: %s got %0d expected %0d",
                     checked, what, got, want);
            err_count++;
        endtask

        task check(answer_t got);
            answer_t want;
            if (pending.size() == 0)
            begin
                report("unexpected word", 1, 0);
                return;
            end
            want = pending.pop_front();
            if (got.status != want.status) report("status", got.status, want.status);
            if (got.hit_count != want.hit_count)
                report("hit_count", got.hit_count, want.hit_count);
            if (got.position_out != want.position_out)
                report("position_out", got.position_out, want.position_out);
            if (got.last_hit != want.last_hit) report("last_hit", got.last_hit, want.last_hit);
            checked++;
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [spam_pkg::CFG_W-1:0] cfg_data;

    spam_in_if  item_ch ();
    spam_out_if result_ch ();

    sparse_pair_associative_memory_core u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_ch.sink),
        .result   (result_ch.source),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    memory_scoreboard sb;
    int  cycles;
    int  idle_mode;
    int  words_sent;
    int  recalls_sent;
    int  fetch_hits;

    initial clk = 0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (result_ch.status == spam_pkg::ST_OK && result_ch.last_hit) fetch_hits++;
            sb.check({result_ch.status, result_ch.hit_count,
                      result_ch.position_out, result_ch.last_hit});
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (idle_mode == 2 || idle_mode == 3)
            result_ch.ready <= ($urandom_range(99) >= ((idle_mode == 2) ? 60 : 6));
        else
            result_ch.ready <= 1'b1;
    end

    task automatic send_word(input logic [spam_pkg::MODE_W-1:0] md,
                             input logic [spam_pkg::POS_W-1:0] ps, input logic lst);
        int pct;
        pct = (idle_mode == 1) ? 60 : ((idle_mode == 3) ? 6 : 0);
        while ($urandom_range(99) < pct)
        begin
            @(negedge clk);
            item_ch.valid <= 1'b0;
        end
        @(negedge clk);
        item_ch.valid    <= 1'b1;
        item_ch.mode     <= md;
        item_ch.position <= ps;
        item_ch.last     <= lst;
        do
            @(posedge clk);
        while (!item_ch.ready);
        sb.note(md, ps, lst);
        words_sent++;
        if (md == spam_pkg::MODE_RECALL) recalls_sent++;
    endtask

    task automatic go_idle();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_sparsity(input logic [spam_pkg::CFG_W-1:0] v);
        go_idle();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        sb.set_sparsity(v);
    endtask

    task automatic send_key(input int n, input bit broken);
        logic [spam_pkg::DIM-1:0] mask;
        int left;
        int b;
        mask = '0;
        while ($countones(mask) < n && n <= spam_pkg::DIM)
            mask[$urandom_range(spam_pkg::DIM-1)] = 1'b1;
        left = $countones(mask);
        b = -1;
        for (int p = 0; p < spam_pkg::DIM; p++)
        begin
            if (mask[p])
            begin
                left--;
                if (broken && b >= 0 && $urandom_range(3) == 0)
                    send_word(spam_pkg::MODE_KEY, spam_pkg::POS_W'(b), 1'b0);
                send_word(spam_pkg::MODE_KEY, spam_pkg::POS_W'(p), left == 0);
                b = p;
            end
        end
        if (n > spam_pkg::MAX_POP) send_word(spam_pkg::MODE_KEY, 6'd63, 1'b1);
    endtask

    task automatic run_sequence();
        int n;
        int r;
        int stores;
        int fetches;
        r = $urandom_range(99);
        if (r < 5) n = spam_pkg::MAX_POP;
        else if (r < 8) n = spam_pkg::MAX_POP + 1;
        else if (r < 14) n = $urandom_range(1);
        else n = $urandom_range(2, 6);
        send_key(n, $urandom_range(9) == 0);
        stores = (n > 8) ? $urandom_range(1, 3) : $urandom_range(1, 10);
        for (int i = 0; i < stores; i++)
        begin
            r = $urandom_range(99);
            if (r < 70)
                send_word(spam_pkg::MODE_STORE, spam_pkg::POS_W'($urandom), 1'($urandom));
            else if (r < 90)
                send_word(spam_pkg::MODE_DELETE, spam_pkg::POS_W'($urandom), 1'($urandom));
            else
                send_word(spam_pkg::MODE_W'($urandom_range(MODE_SPARE_A, MODE_SPARE_C)),
                          spam_pkg::POS_W'($urandom), 1'($urandom));
        end
        if ($urandom_range(3) != 0) send_key($urandom_range(2, 4), 0);
        send_word(spam_pkg::MODE_RECALL, spam_pkg::POS_W'($urandom), 1'($urandom));
        fetches = $urandom_range(1, 12);
        for (int i = 0; i < fetches; i++)
            send_word(spam_pkg::MODE_FETCH, spam_pkg::POS_W'($urandom), 1'($urandom));
    endtask

    logic [spam_pkg::CFG_W-1:0] phase_cfg [6];
    int phase_start;

    initial
    begin
        sb = new();
        cycles = 0;
        idle_mode = 0;
        words_sent = 0;
        recalls_sent = 0;
        fetch_hits = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.mode = '0;
        item_ch.position = '0;
        item_ch.last = 1'b0;
        result_ch.ready = 1'b1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words
        send_word(spam_pkg::MODE_FETCH, 6'd0, 1'b0);
        send_word(spam_pkg::MODE_RECALL, 6'd63, 1'b1);
        send_word(spam_pkg::MODE_KEY, 6'd0, 1'b0);
        send_word(spam_pkg::MODE_KEY, 6'd63, 1'b1);
        send_word(spam_pkg::MODE_STORE, 6'd0, 1'b0);
        send_word(spam_pkg::MODE_STORE, 6'd63, 1'b1);
        send_word(spam_pkg::MODE_DELETE, 6'd63, 1'b0);
        send_word(spam_pkg::MODE_DELETE, 6'd63, 1'b0);
        send_word(spam_pkg::MODE_RECALL, 6'd0, 1'b0);
        send_word(spam_pkg::MODE_FETCH, 6'd63, 1'b1);
        send_word(spam_pkg::MODE_FETCH, 6'd0, 1'b0);
        send_word(spam_pkg::MODE_FETCH, 6'd0, 1'b0);
        send_word(MODE_SPARE_A, 6'd21, 1'b1);
        send_word(MODE_SPARE_B, 6'd42, 1'b0);
        send_word(MODE_SPARE_C, 6'd63, 1'b1);
        send_word(spam_pkg::MODE_KEY, 6'd30, 1'b0);
        send_word(spam_pkg::MODE_KEY, 6'd10, 1'b1);
        send_word(spam_pkg::MODE_KEY, 6'd5, 1'b1);
        send_word(spam_pkg::MODE_STORE, 6'd7, 1'b0);
        send_word(spam_pkg::MODE_RECALL, 6'd0, 1'b0);
        send_word(spam_pkg::MODE_FETCH, 6'd0, 1'b0);

        // counter wrap on one pair row
        send_word(spam_pkg::MODE_KEY, 6'd1, 1'b0);
        send_word(spam_pkg::MODE_KEY, 6'd2, 1'b1);
        for (int i = 0; i < 258; i++) send_word(spam_pkg::MODE_STORE, 6'd5, 1'b0);
        send_word(spam_pkg::MODE_RECALL, 6'd0, 1'b0);
        send_word(spam_pkg::MODE_FETCH, 6'd0, 1'b0);

        phase_cfg[0] = 7'd1;
        phase_cfg[1] = 7'd64;
        phase_cfg[2] = 7'd0;
        phase_cfg[3] = 7'd127;
        phase_cfg[4] = 7'd10;
        phase_cfg[5] = spam_pkg::CFG_W'($urandom_range(2, 63));
        for (int ph = 0; ph < 6; ph++)
        begin
            write_sparsity(phase_cfg[ph]);
            idle_mode = ph % 4;
            phase_start = words_sent;
            while (words_sent - phase_start < 150)
            begin
                run_sequence();
                // sender holds off until the memory has answered everything
                if (ph == 2 && words_sent - phase_start > 75 && words_sent - phase_start < 95)
                    go_idle();
            end
        end

        go_idle();
        $display("sent %0d words with %0d recalls over six sparsity settings", words_sent,
                 recalls_sent);
        $display("checked %0d result words, %0d final hits fetched", sb.checked, fetch_hits);
        if (sb.err_count == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
